// ----- hw/rtl/mpm_pkg.sv -----
// Shared types and codes of the multi-pattern matcher.
package mpm_pkg;

  typedef enum logic [1:0] {
    OP_CLEAR   = 2'd0,
    OP_PATTERN = 2'd1,
    OP_BUILD   = 2'd2,
    OP_TEXT    = 2'd3
  } op_e;

  typedef enum logic [4:0] {
    S_BOOT,
    S_IDLE,
    S_CLEAR,
    S_P_RD,
    S_P_WT,
    S_P_NEW,
    S_P_LAST,
    S_P_CNT,
    S_B_INIT,
    S_B_POP,
    S_B_X,
    S_B_ROW,
    S_B_SYM,
    S_B_CH,
    S_B_CHW,
    S_B_WF,
    S_T_RD,
    S_T_WT,
    S_T_V,
    S_T_VW,
    S_T_END,
    S_DONE
  } state_e;

  localparam int unsigned SymW   = 5;
  localparam int unsigned CountW = 16;

endpackage

// ----- hw/rtl/mpm_ram.sv -----
// Simple dual-port memory with one write port and a registered read port.
module mpm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- hw/rtl/multi_pattern_matcher.sv -----
// Aho-Corasick multi-pattern counter: trie build, failure links and text scan.
// A text symbol off the alphabet just resets the match; any other one costs work per
// failure step and per failure-chain node examined. A build costs work per node, per
// child and per failure step.
// The next request is taken in the cycle after the strobe, which cannot be stalled.
// After reset the block zeroes the root entry in its boot state, then takes requests.
module multi_pattern_matcher
  import mpm_pkg::*;
#(
  parameter int unsigned MAX_NODES = 4096,
  parameter int unsigned ALPHABET  = 26
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        op_i,
  input  logic [SymW-1:0]   symbol_i,
  input  logic              last_i,
  output logic              done_o,
  output logic [CountW-1:0] total_found_o,
  output logic              trie_full_o,
  output logic              end_mark_o
);

  localparam int unsigned NW    = $clog2(MAX_NODES);
  localparam int unsigned SW    = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
  localparam int unsigned RowW  = ALPHABET * NW;
  localparam int unsigned CntW  = CountW + 1;
  localparam logic [NW:0] MaxN  = (NW+1)'(MAX_NODES);
  localparam logic [SW-1:0] SymLast = SW'(ALPHABET - 1);
  localparam logic [8:0]  AlphaN = 9'(ALPHABET);

  state_e state_q, state_d;

  logic [NW:0]       nc_q, nc_d;
  logic [NW-1:0]     ins_q, ins_d, match_q, match_d, now_q, now_d;
  logic [NW-1:0]     x_q, x_d, fx_q, fx_d, f_q, f_d;
  logic [NW:0]       head_q, head_d, tail_q, tail_d;
  logic [SW-1:0]     s_q, s_d;
  logic [RowW-1:0]   rowx_q, rowx_d;
  logic [CountW-1:0] total_q, total_d;
  logic              ovf_q, ovf_d, drop_q, drop_d, last_q, last_d;
  logic [SymW-1:0]   sym_q, sym_d;

  logic              row_we, fl_we, cn_we, qu_we;
  logic [NW-1:0]     row_wa, row_ra, fl_wa, fl_ra, cn_wa, cn_ra, qu_wa, qu_ra;
  logic [RowW-1:0]   row_wd, row_rd, row_mod;
  logic [NW-1:0]     fl_wd, fl_rd, qu_wd, qu_rd;
  logic [CntW-1:0]   cn_wd, cn_rd;

  logic [SW-1:0]     symi;
  logic              sym_ok;
  logic [NW-1:0]     ch_sym, ch_s, c_node;
  logic [CountW:0]   sum;

  mpm_ram #(.Width(RowW), .Depth(MAX_NODES)) u_row (
    .clk_i, .we_i(row_we), .waddr_i(row_wa), .wdata_i(row_wd),
    .raddr_i(row_ra), .rdata_o(row_rd)
  );
  mpm_ram #(.Width(NW), .Depth(MAX_NODES)) u_fail (
    .clk_i, .we_i(fl_we), .waddr_i(fl_wa), .wdata_i(fl_wd),
    .raddr_i(fl_ra), .rdata_o(fl_rd)
  );
  mpm_ram #(.Width(CntW), .Depth(MAX_NODES)) u_cnt (
    .clk_i, .we_i(cn_we), .waddr_i(cn_wa), .wdata_i(cn_wd),
    .raddr_i(cn_ra), .rdata_o(cn_rd)
  );
  mpm_ram #(.Width(NW), .Depth(MAX_NODES)) u_queue (
    .clk_i, .we_i(qu_we), .waddr_i(qu_wa), .wdata_i(qu_wd),
    .raddr_i(qu_ra), .rdata_o(qu_rd)
  );

  assign symi   = SW'(sym_q);
  assign sym_ok = {4'd0, sym_q} < AlphaN;
  assign ch_sym = row_rd[symi*NW +: NW];
  assign ch_s   = row_rd[s_q*NW +: NW];
  assign c_node = rowx_q[s_q*NW +: NW];
  assign sum    = {1'b0, total_q} + {1'b0, cn_rd[CntW-1:1]};

  always_comb begin
    row_mod = row_rd;
    row_mod[symi*NW +: NW] = nc_q[NW-1:0];
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_BOOT:  state_d = S_IDLE;
      S_IDLE: begin
        if (start) begin
          unique case (op_e'(op_i))
            OP_CLEAR:   state_d = S_CLEAR;
            OP_PATTERN: state_d = S_P_RD;
            OP_BUILD:   state_d = S_B_INIT;
            OP_TEXT:    state_d = S_T_RD;
            default:    state_d = S_IDLE;
          endcase
        end
      end
      S_CLEAR: state_d = S_DONE;
      S_P_RD:  state_d = (drop_q || !sym_ok) ? S_P_LAST : S_P_WT;
      S_P_WT: begin
        if (ch_sym != '0)     state_d = S_P_LAST;
        else if (nc_q < MaxN) state_d = S_P_NEW;
        else                  state_d = S_P_LAST;
      end
      S_P_NEW:  state_d = S_P_LAST;
      S_P_LAST: state_d = (last_q && !drop_q) ? S_P_CNT : S_DONE;
      S_P_CNT:  state_d = S_DONE;
      S_B_INIT: state_d = S_B_POP;
      S_B_POP:  state_d = (head_q < tail_q) ? S_B_X : S_DONE;
      S_B_X:    state_d = S_B_ROW;
      S_B_ROW:  state_d = S_B_SYM;
      S_B_SYM: begin
        if (c_node == '0)  state_d = (s_q == SymLast) ? S_B_POP : S_B_SYM;
        else if (x_q == '0) state_d = S_B_WF;
        else                state_d = S_B_CH;
      end
      S_B_CH:  state_d = S_B_CHW;
      S_B_CHW: state_d = (now_q != '0 && ch_s == '0) ? S_B_CH : S_B_WF;
      S_B_WF:  state_d = (s_q == SymLast) ? S_B_POP : S_B_SYM;
      S_T_RD:  state_d = sym_ok ? S_T_WT : S_T_END;
      S_T_WT: begin
        if (now_q != '0 && ch_sym == '0) state_d = S_T_RD;
        else if (ch_sym != '0)           state_d = S_T_V;
        else                             state_d = S_T_END;
      end
      S_T_V:   state_d = S_T_VW;
      S_T_VW:  state_d = (!cn_rd[0] && fl_rd != '0) ? S_T_V : S_T_END;
      S_T_END: state_d = S_DONE;
      S_DONE:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    nc_d = nc_q;  ins_d = ins_q;  match_d = match_q;  now_d = now_q;
    x_d = x_q;  fx_d = fx_q;  f_d = f_q;  head_d = head_q;  tail_d = tail_q;
    s_d = s_q;  rowx_d = rowx_q;  total_d = total_q;  ovf_d = ovf_q;
    drop_d = drop_q;  last_d = last_q;  sym_d = sym_q;
    row_we = 1'b0;  row_wa = '0;  row_wd = '0;  row_ra = now_q;
    fl_we = 1'b0;   fl_wa = '0;   fl_wd = '0;   fl_ra = now_q;
    cn_we = 1'b0;   cn_wa = '0;   cn_wd = '0;   cn_ra = now_q;
    qu_we = 1'b0;   qu_wa = '0;   qu_wd = '0;   qu_ra = head_q[NW-1:0];
    unique case (state_q)
      S_BOOT, S_CLEAR: begin
        // The root row and count are zeroed; every other node is zeroed when made.
        row_we = 1'b1;
        cn_we = 1'b1;
        nc_d = (NW+1)'(1);
        ins_d = '0;  match_d = '0;  total_d = '0;  ovf_d = 1'b0;  drop_d = 1'b0;
      end
      S_IDLE: begin
        if (start) begin
          sym_d = symbol_i;
          last_d = last_i;
          now_d = match_q;
        end
      end
      S_P_RD: begin
        row_ra = ins_q;
        if (!drop_q && !sym_ok) drop_d = 1'b1;
      end
      S_P_WT: begin
        if (ch_sym != '0) begin
          ins_d = ch_sym;
        end else if (nc_q < MaxN) begin
          row_we = 1'b1;
          row_wa = ins_q;
          row_wd = row_mod;
          ins_d = nc_q[NW-1:0];
        end else begin
          ovf_d = 1'b1;
          drop_d = 1'b1;
        end
      end
      S_P_NEW: begin
        row_we = 1'b1;  row_wa = ins_q;
        fl_we = 1'b1;   fl_wa = ins_q;
        cn_we = 1'b1;   cn_wa = ins_q;
        nc_d = nc_q + 1'b1;
      end
      S_P_LAST: begin
        cn_ra = ins_q;
        if (last_q && drop_q) begin
          ins_d = '0;
          drop_d = 1'b0;
        end
      end
      S_P_CNT: begin
        cn_we = 1'b1;
        cn_wa = ins_q;
        cn_wd = cn_rd;
        if (cn_rd[CntW-1:1] != '1) cn_wd[CntW-1:1] = cn_rd[CntW-1:1] + 1'b1;
        ins_d = '0;
      end
      S_B_INIT: begin
        qu_we = 1'b1;
        head_d = '0;
        tail_d = (NW+1)'(1);
      end
      S_B_POP: begin
        if (head_q < tail_q) head_d = head_q + 1'b1;
      end
      S_B_X: begin
        x_d = qu_rd;
        row_ra = qu_rd;
        fl_ra = qu_rd;
      end
      S_B_ROW: begin
        rowx_d = row_rd;
        fx_d = fl_rd;
        s_d = '0;
      end
      S_B_SYM: begin
        if (c_node == '0) begin
          s_d = s_q + 1'b1;
        end else if (x_q == '0) begin
          f_d = '0;
        end else begin
          now_d = fx_q;
        end
      end
      S_B_CH: begin
        row_ra = now_q;
        fl_ra = now_q;
      end
      S_B_CHW: begin
        if (now_q != '0 && ch_s == '0) now_d = fl_rd;
        else f_d = ch_s;
      end
      S_B_WF: begin
        fl_we = 1'b1;
        fl_wa = c_node;
        fl_wd = f_q;
        if (tail_q < MaxN) begin
          qu_we = 1'b1;
          qu_wa = tail_q[NW-1:0];
          qu_wd = c_node;
          tail_d = tail_q + 1'b1;
        end
        s_d = s_q + 1'b1;
      end
      S_T_RD: begin
        if (!sym_ok) match_d = '0;
      end
      S_T_WT: begin
        if (now_q != '0 && ch_sym == '0) begin
          now_d = fl_rd;
        end else begin
          now_d = ch_sym;
          match_d = ch_sym;
        end
      end
      S_T_V: ;
      S_T_VW: begin
        if (!cn_rd[0]) begin
          total_d = sum[CountW] ? '1 : sum[CountW-1:0];
          cn_we = 1'b1;
          cn_wa = now_q;
          cn_wd = {cn_rd[CntW-1:1], 1'b1};
          now_d = fl_rd;
        end
      end
      S_T_END: begin
        if (last_q) match_d = '0;
      end
      S_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_BOOT;
      nc_q    <= (NW+1)'(1);
      ins_q   <= '0;
      match_q <= '0;
      total_q <= '0;
      ovf_q   <= 1'b0;
      drop_q  <= 1'b0;
      head_q  <= '0;
      tail_q  <= '0;
      s_q     <= '0;
    end else begin
      state_q <= state_d;
      nc_q    <= nc_d;
      ins_q   <= ins_d;
      match_q <= match_d;
      total_q <= total_d;
      ovf_q   <= ovf_d;
      drop_q  <= drop_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      s_q     <= s_d;
    end
  end

  always_ff @(posedge clk_i) begin
    now_q  <= now_d;
    x_q    <= x_d;
    fx_q   <= fx_d;
    f_q    <= f_d;
    rowx_q <= rowx_d;
    last_q <= last_d;
    sym_q  <= sym_d;
  end

  assign busy          = (state_q != S_IDLE);
  assign done_o        = (state_q == S_DONE);
  assign total_found_o = total_q;
  assign trie_full_o   = ovf_q;
  assign end_mark_o    = last_q;

  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe longer than one cycle");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("request accepted without going busy");

  a_node_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (nc_q != '0) && (nc_q <= MaxN)) else $error("node count out of range");

  a_full_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovf_q && state_q != S_CLEAR && state_q != S_BOOT) |=> ovf_q)
    else $error("overflow flag dropped without a clear");

endmodule

// ----- bench/multi_pattern_matcher_test.sv -----
// Self-checking testbench of the Aho-Corasick multi-pattern counter.
`timescale 1ns / 100ps

module multi_pattern_matcher_test
  import mpm_pkg::*;
();

  localparam int unsigned NodeLimit = 4096;
  localparam int unsigned Letters   = 26;
  localparam int unsigned CountTop  = 65535;
  localparam int unsigned StallLimit = 1000000;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [1:0]        op_i = OP_CLEAR;
  logic [SymW-1:0]   symbol_i = '0;
  logic              last_i = 1'b0;
  logic              done_o;
  logic [CountW-1:0] total_found_o;
  logic              trie_full_o;
  logic              end_mark_o;

  multi_pattern_matcher DUT (.*);

  always #2 clk_i = ~clk_i;

  typedef struct packed {
    logic [CountW-1:0] total;
    logic              full;
    logic              mark;
  } tally_t;

  typedef struct {
    op_e         op;
    logic [4:0]  sym;
    logic        last;
    bit          typed;
    int unsigned total;
    bit          full;
  } row_t;

  // Software copy of the matcher state.
  int unsigned kids[int unsigned];
  int unsigned links[int unsigned];
  int unsigned hits[int unsigned];
  bit          seen[int unsigned];
  int unsigned nodes, ins_at, scan_at, total_sum;
  bit          overflowed, dropping;

  tally_t      pending[$];
  int unsigned errors, accepted, results, idle_pct, stall_cycles;
  int unsigned n_pat, n_txt, n_build, n_clear;

  function automatic int unsigned kid(int unsigned n, int unsigned s);
    if (s >= Letters) return 0;
    return kids.exists(n * Letters + s) ? kids[n * Letters + s] : 0;
  endfunction

  function automatic int unsigned link_of(int unsigned n);
    return links.exists(n) ? links[n] : 0;
  endfunction

  function automatic void wipe_trie();
    kids.delete(); links.delete(); hits.delete(); seen.delete();
    nodes = 1; ins_at = 0; scan_at = 0; total_sum = 0;
    overflowed = 0; dropping = 0;
  endfunction

  function automatic void add_pattern_symbol(int unsigned s, bit last);
    int unsigned nxt;
    if (!dropping) begin
      if (s >= Letters) begin
        dropping = 1;
      end else begin
        nxt = kid(ins_at, s);
        if (nxt == 0) begin
          if (nodes < NodeLimit) begin
            nxt = nodes;
            nodes++;
            kids[ins_at * Letters + s] = nxt;
          end else begin
            overflowed = 1;
            dropping = 1;
          end
        end
        if (!dropping) ins_at = nxt;
      end
    end
    if (last) begin
      if (!dropping) begin
        if (!hits.exists(ins_at)) hits[ins_at] = 0;
        if (hits[ins_at] < CountTop) hits[ins_at]++;
      end
      ins_at = 0;
      dropping = 0;
    end
  endfunction

  function automatic void link_trie();
    int unsigned order[$];
    int unsigned x, c, p, f, guard;
    order.push_back(0);
    links[0] = 0;
    while (order.size() > 0) begin
      x = order.pop_front();
      for (int unsigned s = 0; s < Letters; s++) begin
        c = kid(x, s);
        if (c == 0) continue;
        f = 0;
        if (x != 0) begin
          p = link_of(x);
          guard = 0;
          while (p != 0 && kid(p, s) == 0 && guard < NodeLimit) begin
            p = link_of(p);
            guard++;
          end
          f = kid(p, s);
        end
        links[c] = f;
        order.push_back(c);
      end
    end
  endfunction

  function automatic void scan_symbol(int unsigned s, bit last);
    int unsigned at, guard;
    if (s >= Letters) begin
      scan_at = 0;
    end else begin
      at = scan_at;
      guard = 0;
      while (at != 0 && kid(at, s) == 0 && guard < NodeLimit) begin
        at = link_of(at);
        guard++;
      end
      at = kid(at, s);
      scan_at = at;
      guard = 0;
      while (at != 0 && !seen.exists(at) && guard < NodeLimit) begin
        total_sum += hits.exists(at) ? hits[at] : 0;
        if (total_sum > CountTop) total_sum = CountTop;
        seen[at] = 1;
        at = link_of(at);
        guard++;
      end
    end
    if (last) scan_at = 0;
  endfunction

  function automatic tally_t predict_tally(op_e op, int unsigned s, bit last);
    tally_t t;
    case (op)
      OP_CLEAR:   begin wipe_trie(); n_clear++; end
      OP_PATTERN: begin add_pattern_symbol(s, last); n_pat++; end
      OP_BUILD:   begin link_trie(); n_build++; end
      default:    begin scan_symbol(s, last); n_txt++; end
    endcase
    t.total = total_sum[CountW-1:0];
    t.full  = overflowed;
    t.mark  = last;
    return t;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("MISMATCH %s: got %0d, expected %0d (result %0d)", what, got, want, results);
    errors++;
  endtask

  // Drives one request and records its expected result once it is taken.
  task automatic issue(op_e op, logic [4:0] s, logic last, bit typed = 0,
                       int unsigned want_total = 0, bit want_full = 0);
    tally_t t;
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    start    <= 1'b1;
    op_i     <= op;
    symbol_i <= s;
    last_i   <= last;
    do @(posedge clk_i); while (busy);
    t = predict_tally(op, s, last);
    if (typed) begin
      t.total = want_total[CountW-1:0];
      t.full  = want_full;
    end
    pending.push_back(t);
    accepted++;
  endtask

  always @(posedge clk_i) begin
    tally_t want;
    if (rst_ni && done_o) begin
      results++;
      if (pending.size() == 0) begin
        report_mismatch("outstanding requests", 0, 1);
      end else begin
        want = pending.pop_front();
        if (total_found_o !== want.total)
          report_mismatch("total_found", total_found_o, want.total);
        if (trie_full_o !== want.full) report_mismatch("trie_full", trie_full_o, want.full);
        if (end_mark_o !== want.mark) report_mismatch("end_mark", end_mark_o, want.mark);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= StallLimit) begin
      $display("Watchdog expired after %0d quiet cycles", stall_cycles);
      $display("Verification failed");
      $finish;
    end
  end

  // Random round: 1-5 patterns, small or full alphabet, usually a build, texts.
  task automatic random_round();
    int unsigned k, len, span;
    span = $urandom_range(1, 3) == 1 ? Letters : $urandom_range(2, 4);
    if ($urandom_range(9) == 0) issue(OP_CLEAR, 5'($urandom), 1'($urandom));
    k = $urandom_range(1, 5);
    repeat (k) begin
      len = $urandom_range(1, 4);
      for (int unsigned i = 0; i < len; i++)
        issue(OP_PATTERN, ($urandom_range(40) == 0) ? 5'($urandom_range(26, 31))
              : 5'($urandom_range(span - 1)), i == len - 1);
    end
    if ($urandom_range(7) != 0) issue(OP_BUILD, 5'($urandom), 1'($urandom));
    k = $urandom_range(4, 14);
    for (int unsigned i = 0; i < k; i++)
      issue(OP_TEXT, ($urandom_range(30) == 0) ? 5'($urandom_range(26, 31))
            : 5'($urandom_range(span - 1)), $urandom_range(5) == 0);
    // Noise with any symbol and end mark, and any op but a clear.
    if ($urandom_range(3) == 0) issue(op_e'($urandom_range(1, 3)), 5'($urandom), 1'($urandom));
  endtask

  row_t plan[] = '{
    '{OP_TEXT,    5'd0,  1'b1, 1, 0, 0},
    '{OP_CLEAR,   5'd31, 1'b0, 1, 0, 0},
    '{OP_PATTERN, 5'd0,  1'b0, 1, 0, 0},
    '{OP_PATTERN, 5'd1,  1'b1, 1, 0, 0},
    '{OP_PATTERN, 5'd1,  1'b0, 1, 0, 0},
    '{OP_PATTERN, 5'd31, 1'b0, 1, 0, 0},
    '{OP_PATTERN, 5'd2,  1'b1, 1, 0, 0},
    '{OP_PATTERN, 5'd25, 1'b1, 1, 0, 0},
    '{OP_PATTERN, 5'd1,  1'b1, 0, 0, 0},
    '{OP_TEXT,    5'd0,  1'b0, 0, 0, 0},
    '{OP_TEXT,    5'd1,  1'b1, 0, 0, 0},
    '{OP_BUILD,   5'd31, 1'b1, 0, 0, 0},
    '{OP_TEXT,    5'd0,  1'b0, 0, 0, 0},
    '{OP_TEXT,    5'd1,  1'b0, 0, 0, 0},
    '{OP_TEXT,    5'd30, 1'b0, 0, 0, 0},
    '{OP_TEXT,    5'd25, 1'b0, 0, 0, 0},
    '{OP_TEXT,    5'd1,  1'b1, 0, 0, 0},
    '{OP_BUILD,   5'd0,  1'b0, 0, 0, 0},
    '{OP_CLEAR,   5'd0,  1'b1, 1, 0, 0}
  };

  initial begin
    wipe_trie();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    idle_pct = 0;
    foreach (plan[i])
      issue(plan[i].op, plan[i].sym, plan[i].last, plan[i].typed, plan[i].total, plan[i].full);

    idle_pct = 26;
    while (accepted < 450) random_round();
    idle_pct = 68;
    while (accepted < 850) random_round();
    idle_pct = 0;
    while (accepted < 1250) random_round();

    start <= 1'b0;
    while (pending.size() != 0) @(posedge clk_i);
    repeat (64) @(posedge clk_i);

    $display("Covered %0d requests (%0d pattern, %0d text, %0d build, %0d clear), %0d results.",
             accepted, n_pat, n_txt, n_build, n_clear, results);
    $display("Rounds mixed letters outside the alphabet and idle gaps; %0d mismatches.", errors);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/mpm_pkg.sv
hw/rtl/mpm_ram.sv
hw/rtl/multi_pattern_matcher.sv
bench/multi_pattern_matcher_test.sv
